[design/gcp_pkg.sv]
// Package for the gamma correction pixel block.
// Holds the log2 precision and the constant log2 function used to build tables.
// No dependencies.
package gcp_pkg;

    localparam int LOG_FRAC_BITS = 24;
    localparam int LOG_INT_BITS  = 4;
    localparam int LOG_BITS      = LOG_FRAC_BITS + LOG_INT_BITS;
    localparam int GAMMA_INT_BITS = 3;

    // Truncated log2 of v (v >= 1) with LOG_FRAC_BITS fraction bits, by the
    // square-and-compare bit recurrence. Evaluated only at elaboration.
    function automatic logic [63:0] f_log2(input logic [31:0] v);
        logic [31:0] e;
        logic [63:0] m;
        logic [63:0] r;
        e = 32'd0;
        for (int k = 0; k < 30; k++) begin
            if ((v >> (e + 32'd1)) != 32'd0) begin
                e = e + 32'd1;
            end
        end
        m = {32'd0, v} << (32'd30 - e);
        r = {32'd0, e} << LOG_FRAC_BITS;
        for (int i = LOG_FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                r = r | (64'd1 << i);
                m = m >> 1;
            end
        end
        return r;
    endfunction

endpackage

[design/gcp_pipe.sv]
// Search pipeline of the gamma correction block: a target stage and one
// compare stage per result bit. Depends on gcp_pkg.
module gcp_pipe #(
    parameter int PIXEL_BITS = 8,
    parameter int GAMMA_BITS = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [GAMMA_BITS-1:0] i_gamma,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_pixel
);
    import gcp_pkg::*;

    localparam int NV = 2 ** PIXEL_BITS;
    localparam int FRAC = GAMMA_BITS - GAMMA_INT_BITS;
    localparam int TW = LOG_BITS + FRAC;
    localparam int PW = LOG_BITS + GAMMA_BITS;
    localparam logic [PIXEL_BITS-1:0] FULL = {PIXEL_BITS{1'b1}};

    typedef logic [LOG_BITS-1:0] t_tab [NV];

    // Table of L(v) = log2(M) - log2(v); entry 0 is never looked up for a search.
    function automatic t_tab f_build();
        t_tab        t;
        logic [63:0] a;
        logic [63:0] b;
        a = f_log2(32'(FULL));
        for (int v = 0; v < NV; v++) begin
            b = (v == 0) ? 64'd0 : f_log2(32'(v));
            t[v] = (a > b) ? LOG_BITS'(a - b) : '0;
        end
        return t;
    endfunction

    localparam t_tab NEG_LOG = f_build();

    logic                  r_vld [PIXEL_BITS+1];
    logic                  r_zero [PIXEL_BITS+1];
    logic [TW-1:0]         r_tgt [PIXEL_BITS+1];
    logic [PIXEL_BITS-1:0] r_y [PIXEL_BITS+1];

    logic [GAMMA_BITS-1:0] w_g;
    assign w_g = (i_gamma == '0) ? GAMMA_BITS'(1) : i_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= PIXEL_BITS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= PIXEL_BITS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_pixel == '0);
            r_tgt[0]  <= TW'({NEG_LOG[i_pixel], {FRAC{1'b0}}});
            r_y[0]    <= '0;
            for (int s = 1; s <= PIXEL_BITS; s++) begin
                logic [PIXEL_BITS-1:0] cand;
                logic [PW-1:0]         prod;
                cand = r_y[s-1] | (PIXEL_BITS'(1) << (PIXEL_BITS - s));
                prod = PW'(w_g) * PW'(NEG_LOG[cand]);
                r_zero[s] <= r_zero[s-1];
                r_tgt[s]  <= r_tgt[s-1];
                r_y[s]    <= (prod >= PW'(r_tgt[s-1])) ? cand : r_y[s-1];
            end
        end
    end

    assign o_valid = r_vld[PIXEL_BITS];
    assign o_pixel = r_zero[PIXEL_BITS] ? '0 : r_y[PIXEL_BITS];
endmodule

[design/gamma_correction_pixel_top.sv]
// Top level of the gamma correction pixel block.
// Holds the APB register and the stall control; depends on gcp_pkg, gcp_pipe.
//
// The block takes one pixel sample per request and returns
// M*(x/M)^(1/g), truncated, where M is full scale and g is the gamma register
// in unsigned fixed point with GAMMA_FRAC_BITS fraction bits (reset 4.0; zero
// acts as one LSB). It accepts a request every clock when not stalled; one
// stage looks up the target log, then one stage per result bit tests a
// candidate with one table read, one multiply and one compare. The whole
// pipeline holds while a result waits at the output, so nothing is lost or
// repeated. Write the gamma register at byte address 0 only while the block
// is idle.
module gamma_correction_pixel_top #(
    parameter int PIXEL_BITS      = 8,
    parameter int GAMMA_FRAC_BITS = 6
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [PIXEL_BITS-1:0]                           i_pixel_in,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [PIXEL_BITS-1:0]                           o_pixel_out,
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [2:0]                                      paddr,
    input  logic [31:0]                                     pwdata,
    output logic [31:0]                                     prdata,
    output logic                                            pready
);
    import gcp_pkg::*;

    localparam int GAMMA_BITS = GAMMA_FRAC_BITS + GAMMA_INT_BITS;

    logic [GAMMA_BITS-1:0] r_gamma;
    logic                  w_en;

    // The gamma register is the only register, at byte address zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_BITS'(4) << GAMMA_FRAC_BITS;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_gamma <= pwdata[GAMMA_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_gamma) : 32'd0;

    // The pipeline advances unless a finished result is still waiting.
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    gcp_pipe #(
        .PIXEL_BITS(PIXEL_BITS),
        .GAMMA_BITS(GAMMA_BITS)
    ) u_pipe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(i_valid),
        .i_pixel(i_pixel_in),
        .i_gamma(r_gamma),
        .o_valid(o_valid),
        .o_pixel(o_pixel_out)
    );
endmodule

[design/gcp_checker.sv]
// Port-level checker for the gamma correction pixel block, with its bind.
// Depends on gamma_correction_pixel_top.
module gcp_checker #(
    parameter int PIXEL_BITS = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_ready,
    input logic                  pready,
    input logic [PIXEL_BITS-1:0] o_pixel_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out))
        else $error("result changed while stalled");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while output stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind gamma_correction_pixel_top gcp_checker #(.PIXEL_BITS(PIXEL_BITS)) u_gcp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_ready    (o_ready),
    .pready     (pready),
    .o_pixel_out(o_pixel_out)
);

[tb/gamma_correction_pixel_top_test.sv]
// Testbench for the gamma correction pixel block: drives pixel requests and APB
// gamma writes, predicts each corrected sample in fixed-point log2, and checks.
// Depends on gamma_correction_pixel_top (and gcp_pkg through it).
`timescale 1ns / 100ps

class gamma_scoreboard;
    bit [8:0]     gamma_reg;
    logic [7:0]   pending_pixels[$];
    int           mismatches;
    int           results_checked;
    longint       full_scale_log;

    function new();
        gamma_reg = 9'd256;
        mismatches = 0;
        results_checked = 0;
        full_scale_log = fixed_log2(255);
    endfunction

    // Truncated log2 with 24 fraction bits, by squaring the normalized mantissa.
    function longint fixed_log2(int unsigned v);
        int unsigned  e;
        bit [63:0]    m;
        bit [63:0]    r;
        e = 0;
        while (e < 30 && (v >> (e + 1)) != 0) e++;
        m = 64'(v) << (30 - e);
        r = 64'(e) << 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                r |= 64'd1 << i;
                m >>= 1;
            end
        end
        return longint'(r);
    endfunction

    function longint darkness(int unsigned v);
        longint b;
        b = fixed_log2(v);
        return (full_scale_log > b) ? full_scale_log - b : 0;
    endfunction

    // Largest y whose log distance from full scale, times gamma, still covers x's.
    function logic [7:0] corrected_pixel(logic [7:0] x);
        longint       g;
        longint       target;
        int unsigned  lo, hi, mid;
        if (x == 0) return 8'd0;
        g = (gamma_reg == 0) ? 1 : gamma_reg;
        target = darkness(x) << 6;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            if (g * darkness(mid) >= target) lo = mid;
            else hi = mid - 1;
        end
        return lo[7:0];
    endfunction

    function void note_request(logic [7:0] x);
        pending_pixels.push_back(corrected_pixel(x));
    endfunction

    function void check_result(logic [7:0] got);
        logic [7:0] want;
        if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %0d", got);
            return;
        end
        want = pending_pixels.pop_front();
        results_checked++;
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel_out mismatch: expected %0d, got %0d (gamma %0d)",
                         want, got, gamma_reg);
        end
    endfunction
endclass

module gamma_correction_pixel_top_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_pixel_in;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_pixel_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] GAMMA_ADDR = 3'd0;
    localparam int CYCLE_LIMIT = 400000;

    // Idle percentages for the sender and the receiver, changed per phase.
    int          send_idle_pct;
    int          recv_stall_pct;
    // Cycles for which the receiver holds off completely, counted below.
    int          hold_off_cycles;
    int          cycle_count;
    int          requests_sent;
    int          gamma_settings;
    gamma_scoreboard sb;

    gamma_correction_pixel_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_in (i_pixel_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pixel_out(o_pixel_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The cycle counter guards against a hung pipeline.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: ready is randomized each cycle, and forced low during a hold-off.
    // Results are sampled at the edge, before any new values are driven.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_pixel_out);
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one pixel request and waits for it to be accepted. Valid stays
    // high after acceptance so that requests can follow back to back; it is
    // dropped in idle cycles and by drain().
    task automatic send_pixel(input logic [7:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_in <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(x);
        requests_sent++;
    endtask

    // Waits for all results, then lets the pipeline drain before touching
    // the register.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write of the gamma register, setup phase then access phase; pready is always high.
    task automatic write_gamma(input logic [8:0] g);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GAMMA_ADDR;
        pwdata <= {$urandom} & 32'hFFFF_FE00 | 32'(g);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.gamma_reg = g;
        gamma_settings++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_pixels(input int count);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: send_pixel(8'd0);
                1: send_pixel(8'd255);
                2: send_pixel(8'($urandom_range(8)));
                default: send_pixel(8'($urandom_range(255)));
            endcase
        end
    endtask

    initial begin
        logic [8:0] gamma_list[$];
        sb = new();
        cycle_count = 0;
        requests_sent = 0;
        gamma_settings = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel_in = 8'd0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset gamma of 4.0: black, full scale, each
        // single bit set, and the values just off the ends.
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd254);
        for (int b = 0; b < 8; b++) send_pixel(8'(1 << b));
        send_pixel(8'd128 - 8'd1);
        drain();
        // A zero gamma acts as one LSB; also the top and bottom of the range.
        write_gamma(9'd0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd100);
        send_pixel(8'd255);
        drain();

        // Random part in phases over several gammas, including the extremes.
        gamma_list = '{9'd1, 9'd511, 9'd64, 9'd141, 9'd40, 9'd256, 9'd300, 9'd0};
        foreach (gamma_list[p]) begin
            write_gamma(p == 7 ? 9'($urandom_range(511)) : gamma_list[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            // In one phase the receiver holds off long enough to fill the pipe.
            if (p == 3) hold_off_cycles = 60;
            random_pixels(135);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("Sent %0d pixel requests over %0d gamma settings, %0d results checked.",
                 requests_sent, gamma_settings, sb.results_checked);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("Mismatches: %0d, results missing: %0d",
                     sb.mismatches, sb.pending_pixels.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
